// ===== hw/rtl/slave_command_byte_decoder_defines.svh =====
// Assertion macros for the slave command byte decoder.
// Included by the top level only; no other dependencies.
`ifndef SLAVE_COMMAND_BYTE_DECODER_DEFINES_SVH
`define SLAVE_COMMAND_BYTE_DECODER_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define SCBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define SCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/scbd_pkg.sv =====
// Shared types, command codes and helpers for the slave command byte decoder.
// No dependencies.
package scbd_pkg;

	localparam logic [7:0] CMD_OUTPUT  = 8'hBB;
	localparam logic [7:0] CMD_BATTERY = 8'hCC;
	localparam logic [7:0] CMD_STATUS  = 8'hFF;
	localparam logic [7:0] CMD_SWITCH  = 8'hDD;
	localparam logic [7:0] SWITCH_ACK  = 8'hAA;

	localparam int STATUS_REG_BYTES = 6;
	localparam int STATUS_W         = 8 * STATUS_REG_BYTES;
	localparam int CFG_IDX_W        = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_BYTE  = 2'd1;

	// one decoded byte, handed from the decoder to the result stage
	typedef struct packed {
		logic        tx_status;   // send the status bytes
		logic        tx_switch;   // send the switch byte
		logic [7:0]  sw_byte;
		logic [15:0] output_word;
		logic [15:0] nav_word;
		logic [31:0] battery_word;
		logic        output_done;
		logic        battery_done;
		logic        status_request;
		logic        switch_event;
	} scbd_res_t;

	// status byte k; bytes past the register read as zero
	function automatic logic [7:0] status_byte(input logic [STATUS_W-1:0] bytes,
			input logic [2:0] k);
		logic [7:0] b;
		b = 8'h00;
		for (int i = 0; i < STATUS_REG_BYTES; i++) begin
			if (k == 3'(i)) begin
				b = bytes[8*i +: 8];
			end
		end
		return b;
	endfunction

endpackage

// ===== hw/rtl/scbd_core.sv =====
// Command decoder: transaction state and word assembly, one byte per transfer.
// Depends on scbd_pkg.
module scbd_core import scbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  logic [7:0] switch_byte,
	output scbd_res_t  res
);

	logic [1:0]  oc_q, oc_d;
	logic [1:0]  bc_q, bc_d;
	logic        opend_q, opend_d;
	logic        spend_q, spend_d;
	logic        bpend_q, bpend_d;
	logic        wpend_q, wpend_d;
	logic [15:0] out_q, out_d;
	logic [15:0] nav_q, nav_d;
	logic [31:0] asm_q, asm_d;
	logic [31:0] lat_q, lat_d;
	logic        check;
	logic        idle_after;

	always_comb begin
		oc_d    = oc_q;
		bc_d    = bc_q;
		opend_d = opend_q;
		spend_d = spend_q;
		bpend_d = bpend_q;
		wpend_d = wpend_q;
		out_d   = out_q;
		nav_d   = nav_q;
		asm_d   = asm_q;
		lat_d   = lat_q;
		check   = 1'b1;
		res     = '0;
		res.sw_byte = switch_byte;

		if (oc_q == 2'd0) begin
			out_d = '0;
			nav_d = '0;
		end else if (bc_q == 2'd0) begin
			asm_d = '0;
		end

		if (opend_q) begin
			case (oc_q)
				2'd0: begin
					out_d = out_d | {rx_byte, 8'h00};
					oc_d  = 2'd1;
				end
				2'd1: begin
					out_d = out_d | {8'h00, rx_byte};
					oc_d  = 2'd2;
				end
				2'd2: begin
					nav_d = nav_d | {rx_byte, 8'h00};
					oc_d  = 2'd3;
				end
				default: begin
					nav_d   = nav_d | {8'h00, rx_byte};
					oc_d    = 2'd0;
					opend_d = 1'b0;
					res.output_done = 1'b1;
					check   = 1'b0;
				end
			endcase
		end else if (spend_q) begin
			res.tx_status = 1'b1;
			spend_d = 1'b0;
		end else if (bpend_q) begin
			case (bc_q)
				2'd0: begin
					asm_d = {rx_byte, 24'h0};
					bc_d  = 2'd1;
				end
				2'd1: begin
					asm_d = asm_d | {8'h00, rx_byte, 16'h0};
					bc_d  = 2'd2;
				end
				2'd2: begin
					asm_d = asm_d | {16'h0, rx_byte, 8'h00};
					bc_d  = 2'd3;
				end
				default: begin
					asm_d   = asm_d | {24'h0, rx_byte};
					lat_d   = asm_d | {24'h0, rx_byte};
					bc_d    = 2'd0;
					bpend_d = 1'b0;
					res.battery_done = 1'b1;
					check   = 1'b0;
				end
			endcase
		end else if (wpend_q && rx_byte == SWITCH_ACK) begin
			wpend_d = 1'b0;
			res.switch_event = 1'b1;
			check   = 1'b0;
		end else if (wpend_q) begin
			res.tx_switch = 1'b1;
			wpend_d = 1'b0;
		end

		idle_after = !opend_d && !spend_d && !bpend_d && !wpend_d;
		if (check && idle_after) begin
			case (rx_byte)
				CMD_OUTPUT:  opend_d = 1'b1;
				CMD_STATUS: begin
					spend_d = 1'b1;
					res.status_request = 1'b1;
				end
				CMD_BATTERY: bpend_d = 1'b1;
				CMD_SWITCH: begin
					wpend_d = 1'b1;
					res.switch_event = 1'b1;
				end
				default: ;
			endcase
		end

		res.output_word  = out_d;
		res.nav_word     = nav_d;
		res.battery_word = lat_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q    <= '0;
			bc_q    <= '0;
			opend_q <= 1'b0;
			spend_q <= 1'b0;
			bpend_q <= 1'b0;
			wpend_q <= 1'b0;
			out_q   <= '0;
			nav_q   <= '0;
			asm_q   <= '0;
			lat_q   <= '0;
		end else if (accept) begin
			oc_q    <= oc_d;
			bc_q    <= bc_d;
			opend_q <= opend_d;
			spend_q <= spend_d;
			bpend_q <= bpend_d;
			wpend_q <= wpend_d;
			out_q   <= out_d;
			nav_q   <= nav_d;
			asm_q   <= asm_d;
			lat_q   <= lat_d;
		end
	end

endmodule

// ===== hw/rtl/scbd_tx.sv =====
// Result register: holds one decoded byte and plays out its one or more results.
// Depends on scbd_pkg.
module scbd_tx import scbd_pkg::*; #(
	parameter int STATUS_COUNT = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  scbd_res_t           res,
	input  logic [STATUS_W-1:0] status_bytes,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                tx_valid,
	output logic [7:0]          tx_byte,
	output logic                last,
	output logic [15:0]         output_word,
	output logic [15:0]         nav_word,
	output logic [31:0]         battery_word,
	output logic                output_done,
	output logic                battery_done,
	output logic                status_request,
	output logic                switch_event
);

	localparam int IdxW = (STATUS_COUNT > 1) ? $clog2(STATUS_COUNT) : 1;
	localparam logic [IdxW-1:0] IdxLast = IdxW'(STATUS_COUNT - 1);

	scbd_res_t       res_q;
	logic            valid_q;
	logic [IdxW-1:0] idx_q;
	logic            xfer;

	assign xfer     = valid_q && out_ready;
	assign last     = !res_q.tx_status || (idx_q == IdxLast);
	assign can_load = !valid_q || (xfer && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (xfer && last) begin
			valid_q <= 1'b0;
		end else if (xfer) begin
			idx_q   <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid      = valid_q;
	assign tx_valid       = res_q.tx_status || res_q.tx_switch;
	assign tx_byte        = res_q.tx_status ? status_byte(status_bytes, 3'(idx_q)) :
	                        res_q.tx_switch ? res_q.sw_byte : 8'h00;
	assign output_word    = res_q.output_word;
	assign nav_word       = res_q.nav_word;
	assign battery_word   = res_q.battery_word;
	assign output_done    = res_q.output_done;
	assign battery_done   = res_q.battery_done;
	assign status_request = res_q.status_request;
	assign switch_event   = res_q.switch_event;

endmodule

// ===== hw/rtl/slave_command_byte_decoder.sv =====
// Top level of the slave command byte decoder: config registers, decoder, result stage.
// Depends on scbd_pkg, scbd_core, scbd_tx and slave_command_byte_decoder_defines.svh.
//
//  channel  handshake              payload
//  -------  ---------------------  -------------------------------------------
//  in       in_valid / in_ready    rx_byte
//  out      out_valid / out_ready  tx_valid tx_byte last words and pulses
//  cfg      cfg_valid / cfg_ready  cfg_index cfg_data (0 status bytes, 1 switch)
//
// Cycles: a received byte is decoded in the cycle it is transferred and its
// result sits in the result register from the next cycle; one byte per cycle
// while in_ready is high. A status reply holds the result register for
// STATUS_COUNT out transfers; every other result leaves in a single out transfer.
// in_ready stays high while the result register is empty or its final result
// leaves in the same cycle, so a stalled out channel holds off input.
// Reset clears all decoder state, the config registers and the result valid.
// cfg_ready is always high; writes to unused indexes are dropped.
`include "slave_command_byte_decoder_defines.svh"

module slave_command_byte_decoder import scbd_pkg::*; #(
	parameter int STATUS_COUNT = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 tx_valid,
	output logic [7:0]           tx_byte,
	output logic                 last,
	output logic [15:0]          output_word,
	output logic [15:0]          nav_word,
	output logic [31:0]          battery_word,
	output logic                 output_done,
	output logic                 battery_done,
	output logic                 status_request,
	output logic                 switch_event,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STATUS_W-1:0]  cfg_data
);

	logic [STATUS_W-1:0] status_bytes_q;
	logic [7:0]          switch_byte_q;
	logic                accept;
	scbd_res_t           res;

	assign cfg_ready = 1'b1;

	// config registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_bytes_q <= '0;
			switch_byte_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STATUS_BYTES: status_bytes_q <= cfg_data;
				CFG_SWITCH_BYTE:  switch_byte_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	scbd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.switch_byte (switch_byte_q),
		.res         (res)
	);

	scbd_tx #(
		.STATUS_COUNT (STATUS_COUNT)
	) u_tx (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (accept),
		.res            (res),
		.status_bytes   (status_bytes_q),
		.can_load       (in_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tx_valid       (tx_valid),
		.tx_byte        (tx_byte),
		.last           (last),
		.output_word    (output_word),
		.nav_word       (nav_word),
		.battery_word   (battery_word),
		.output_done    (output_done),
		.battery_done   (battery_done),
		.status_request (status_request),
		.switch_event   (switch_event)
	);

	// a new byte only lands when the held result is finished
	`SCBD_ASSERT_NOW(a_no_overwrite, clk, arst_n, accept, !out_valid || (out_ready && last), "byte accepted over unfinished result")
	// a status reply keeps going until its final byte
	`SCBD_ASSERT_NEXT(a_burst_continues, clk, arst_n, out_valid && out_ready && !last, out_valid && tx_valid, "status reply cut short")
	// a result with nothing to transmit is always the only one of its byte
	`SCBD_ASSERT_NOW(a_quiet_is_last, clk, arst_n, out_valid && !tx_valid, last && tx_byte == 8'h00, "idle result not final")

endmodule
